[rtl/core/input_event_queue_with_autorepeat_defines.svh]
// ----------------------------------------------------------------------------
// Event queue assertion macros
// Shared concurrent assertion helpers; compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_QUEUE_WITH_AUTOREPEAT_DEFINES_SVH
`define INPUT_EVENT_QUEUE_WITH_AUTOREPEAT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define IEQAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// next-cycle implication, checked out of reset
`define IEQAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`else

`define IEQAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IEQAR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/ieqar_pkg.sv]
// ----------------------------------------------------------------------------
// Event queue package
// Types, codes and reset values shared by the event queue modules
// ----------------------------------------------------------------------------
package ieqar_pkg;

    // ring size default
    localparam int RING_DEPTH_DEF = 256;

    // register reset values
    localparam logic [15:0] DELAY_RST  = 16'd500;
    localparam logic [15:0] PERIOD_RST = 16'd33;
    localparam logic [15:0] KEY_RST    = 16'd1;

    // register indexes (word address bits)
    localparam logic [1:0] REG_DELAY  = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_KEY    = 2'd2;

    // request actions
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_POP  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // key values
    localparam logic signed [31:0] KEY_RELEASE = 32'sd0;
    localparam logic signed [31:0] KEY_PRESS   = 32'sd1;
    localparam logic signed [31:0] KEY_REPEAT  = 32'sd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        now_ms;
        logic [15:0]        in_type;
        logic [15:0]        in_code;
        logic signed [31:0] in_value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        out_time_ms;
        logic [15:0]        out_type;
        logic [15:0]        out_code;
        logic signed [31:0] out_value;
        logic [8:0]         pending_count;
        logic [31:0]        pushed_total;
        logic [31:0]        dropped_total;
        logic [31:0]        read_total;
    } t_rsp;

    // one ring entry
    typedef struct packed {
        logic [31:0]        time_ms;
        logic [15:0]        ev_type;
        logic [15:0]        ev_code;
        logic signed [31:0] ev_value;
    } t_slot;

    typedef struct packed {
        logic [15:0] delay_ms;
        logic [15:0] period_ms;
        logic [15:0] key_type;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic exec;    // request without ring read: push, tick, empty pop, unused
        logic rd;      // start ring read for a pop
        logic fin;     // finish pop with read data
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
    } t_stat;

endpackage

[rtl/core/input_event_queue_with_autorepeat.sv]
// ----------------------------------------------------------------------------
// Input event queue with autorepeat
// Timestamped event ring with drop-on-full, single-key repeater, APB config
// ----------------------------------------------------------------------------
// Push, tick, empty pop and unused action write their result straight into the
// result register; a pop that returns an event first passes the registered ring
// read. Throughput: one request per cycle unless results stall; a pop blocks until
// it finishes. Reset: synchronous, active low; clears pointers, counters,
// repeater and result valid, loads register defaults; ring contents not cleared.
module input_event_queue_with_autorepeat #(
    parameter int RING_DEPTH = ieqar_pkg::RING_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ieqar_pkg::t_req  i_in_req,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ieqar_pkg::t_rsp  o_out_rsp,
    // register port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ieqar_pkg::t_cfg  r_cfg;
    ieqar_pkg::t_cmd  cmd;
    ieqar_pkg::t_stat stat;
    logic             cfg_we;

    // register writes
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_ms  <= ieqar_pkg::DELAY_RST;
            r_cfg.period_ms <= ieqar_pkg::PERIOD_RST;
            r_cfg.key_type  <= ieqar_pkg::KEY_RST;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                ieqar_pkg::REG_DELAY:  r_cfg.delay_ms  <= pwdata[15:0];
                ieqar_pkg::REG_PERIOD: r_cfg.period_ms <= pwdata[15:0];
                ieqar_pkg::REG_KEY:    r_cfg.key_type  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[3:2])
            ieqar_pkg::REG_DELAY:  prdata = {16'd0, r_cfg.delay_ms};
            ieqar_pkg::REG_PERIOD: prdata = {16'd0, r_cfg.period_ms};
            ieqar_pkg::REG_KEY:    prdata = {16'd0, r_cfg.key_type};
            default:               prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // controller
    ieqar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_req.action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath
    ieqar_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_req),
        .i_cfg   (r_cfg),
        .o_stat  (stat),
        .o_rsp   (o_out_rsp)
    );

endmodule

[rtl/core/ieqar_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ieqar_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ieqar_ctrl.sv]
// ----------------------------------------------------------------------------
// Event queue controller
// Request handshake, pop sequencing and result valid
// ----------------------------------------------------------------------------
`include "input_event_queue_with_autorepeat_defines.svh"

module ieqar_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_action,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  ieqar_pkg::t_stat    i_stat,
    output ieqar_pkg::t_cmd     o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic take;
    logic accept;
    logic is_pop;

    // ready when idle and the result register is free or draining
    assign take   = (r_state == ST_IDLE) && (!r_out_valid || !i_out_stall);
    assign accept = i_in_valid && take;
    assign is_pop = (i_action == ieqar_pkg::ACT_POP) && !i_stat.empty;

    // commands
    always_comb begin
        o_cmd.exec = accept && !is_pop;
        o_cmd.rd   = accept && is_pop;
        o_cmd.fin  = (r_state == ST_POP);
    end

    // state sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.rd) begin
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec || o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !take;
    assign o_out_valid = r_out_valid;

    // pop read always moves to the finish state
    `IEQAR_ASSERT_NXT(a_rd_to_pop, i_clk, i_rst_n, o_cmd.rd, r_state == ST_POP)
    // result register is free when a pop finishes
    `IEQAR_ASSERT_IMP(a_pop_free, i_clk, i_rst_n, r_state == ST_POP, !r_out_valid)
    // finished pop presents a result
    `IEQAR_ASSERT_NXT(a_fin_valid, i_clk, i_rst_n, o_cmd.fin, r_out_valid)

endmodule

[rtl/core/ieqar_dp.sv]
// ----------------------------------------------------------------------------
// Event queue datapath
// Ring pointers, repeater, counters, ring memory and result register
// ----------------------------------------------------------------------------
`include "input_event_queue_with_autorepeat_defines.svh"

module ieqar_dp #(
    parameter int RING_DEPTH = ieqar_pkg::RING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ieqar_pkg::t_cmd    i_cmd,
    input  ieqar_pkg::t_req    i_req,
    input  ieqar_pkg::t_cfg    i_cfg,
    output ieqar_pkg::t_stat   o_stat,
    output ieqar_pkg::t_rsp    o_rsp
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int SW = $bits(ieqar_pkg::t_slot);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(RING_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(RING_DEPTH - 1);

    logic [AW-1:0]  r_rp;
    logic [AW-1:0]  n_rp;
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  n_fill;
    logic           r_held;
    logic           n_held;
    logic [15:0]    r_held_code;
    logic [15:0]    n_held_code;
    logic [31:0]    r_deadline;
    logic [31:0]    n_deadline;
    logic [31:0]    r_acc;
    logic [31:0]    n_acc;
    logic [31:0]    r_drop;
    logic [31:0]    n_drop;
    logic [31:0]    r_pop;
    logic [31:0]    n_pop;
    ieqar_pkg::t_rsp r_rsp;
    ieqar_pkg::t_rsp n_rsp;

    logic              full;
    logic [AW:0]       wsum;
    logic [AW:0]       wwrap;
    logic              enq;
    ieqar_pkg::t_slot  enq_slot;
    ieqar_pkg::t_slot  rd_slot;
    logic [SW-1:0]     rdata;
    logic              we;
    logic [FW+8:0]     fill_ext;

    assign full = (r_fill == DEPTH_F);

    // tail address: read pointer plus fill level, wrapped once
    assign wsum  = {1'b0, r_rp} + {1'b0, r_fill[AW-1:0]};
    assign wwrap = (wsum >= DEPTH_A) ? (wsum - DEPTH_A) : wsum;

    assign rd_slot = ieqar_pkg::t_slot'(rdata);

    // next state and result
    always_comb begin
        n_rp        = r_rp;
        n_fill      = r_fill;
        n_held      = r_held;
        n_held_code = r_held_code;
        n_deadline  = r_deadline;
        n_acc       = r_acc;
        n_drop      = r_drop;
        n_pop       = r_pop;
        n_rsp       = r_rsp;
        enq         = 1'b0;
        we          = 1'b0;
        enq_slot.time_ms  = i_req.now_ms;
        enq_slot.ev_type  = i_req.in_type;
        enq_slot.ev_code  = i_req.in_code;
        enq_slot.ev_value = i_req.in_value;

        if (i_cmd.exec) begin
            n_rsp        = '0;
            n_rsp.status = ieqar_pkg::ST_NONE;
            case (i_req.action)
                ieqar_pkg::ACT_PUSH: begin
                    enq = 1'b1;
                    // repeater update only for a stored key event
                    if (!full && (i_req.in_type == i_cfg.key_type)) begin
                        if (i_req.in_value == ieqar_pkg::KEY_PRESS) begin
                            n_held      = 1'b1;
                            n_held_code = i_req.in_code;
                            n_deadline  = i_req.now_ms + {16'd0, i_cfg.delay_ms};
                        end else if ((i_req.in_value == ieqar_pkg::KEY_RELEASE) && r_held
                                     && (r_held_code == i_req.in_code)) begin
                            n_held = 1'b0;
                        end
                    end
                end
                ieqar_pkg::ACT_TICK: begin
                    // repeat due: advance deadline and queue a repeat event
                    if (r_held && (i_req.now_ms >= r_deadline)) begin
                        enq               = 1'b1;
                        n_deadline        = r_deadline + {16'd0, i_cfg.period_ms};
                        enq_slot.ev_type  = i_cfg.key_type;
                        enq_slot.ev_code  = r_held_code;
                        enq_slot.ev_value = ieqar_pkg::KEY_REPEAT;
                    end
                end
                default: begin
                end
            endcase
            // enqueue or drop
            if (enq) begin
                if (full) begin
                    n_drop       = r_drop + 32'd1;
                    n_rsp.status = ieqar_pkg::ST_DROP;
                end else begin
                    we           = 1'b1;
                    n_fill       = r_fill + 1'b1;
                    n_acc        = r_acc + 32'd1;
                    n_rsp.status = ieqar_pkg::ST_OK;
                end
            end
        end else if (i_cmd.fin) begin
            // pop completes with ring read data
            n_rsp.status      = ieqar_pkg::ST_OK;
            n_rsp.out_time_ms = rd_slot.time_ms;
            n_rsp.out_type    = rd_slot.ev_type;
            n_rsp.out_code    = rd_slot.ev_code;
            n_rsp.out_value   = rd_slot.ev_value;
            n_rp              = (r_rp == LAST_A) ? '0 : (r_rp + 1'b1);
            n_fill            = r_fill - 1'b1;
            n_pop             = r_pop + 32'd1;
        end

        fill_ext            = {9'd0, n_fill};
        n_rsp.pending_count = fill_ext[8:0];
        n_rsp.pushed_total  = n_acc;
        n_rsp.dropped_total = n_drop;
        n_rsp.read_total    = n_pop;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_fill      <= '0;
            r_held      <= 1'b0;
            r_held_code <= '0;
            r_deadline  <= '0;
            r_acc       <= '0;
            r_drop      <= '0;
            r_pop       <= '0;
        end else begin
            r_rp        <= n_rp;
            r_fill      <= n_fill;
            r_held      <= n_held;
            r_held_code <= n_held_code;
            r_deadline  <= n_deadline;
            r_acc       <= n_acc;
            r_drop      <= n_drop;
            r_pop       <= n_pop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec || i_cmd.fin) begin
            r_rsp <= n_rsp;
        end
    end

    // ring storage
    ieqar_ram #(
        .WIDTH (SW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wwrap[AW-1:0]),
        .i_wdata (enq_slot),
        .i_re    (i_cmd.rd),
        .i_raddr (r_rp),
        .o_rdata (rdata)
    );

    assign o_stat.empty = (r_fill == '0);
    assign o_rsp        = r_rsp;

    // fill level never passes the ring size
    `IEQAR_ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= DEPTH_F)
    // no ring write into a full ring
    `IEQAR_ASSERT_IMP(a_no_wr_full, i_clk, i_rst_n, we, !full)
    // a pop read only starts on a non-empty ring and keeps it until finish
    `IEQAR_ASSERT_NXT(a_rd_fill, i_clk, i_rst_n, i_cmd.rd, r_fill != '0)

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event queue with autorepeat testbench
// Sends push, tick, pop and unused requests and compares every result, field
// by field, with a cycle-free model of the ring, counters and key repeater.
// Registers are rewritten between phases while the block is idle. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          RING_N    = ieqar_pkg::RING_DEPTH_DEF;
    localparam logic [1:0]  ACT_NONE  = 2'd3;
    localparam int          LONG_HOLD = 400;
    localparam int          SETTLE    = 4;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block ports
    logic              in_valid  = 1'b0;
    logic              in_stall;
    ieqar_pkg::t_req   in_req    = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    ieqar_pkg::t_rsp   out_rsp;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [3:0]        paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    input_event_queue_with_autorepeat i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // request and result bookkeeping
    ieqar_pkg::t_req req_todo_q[$];
    ieqar_pkg::t_rsp rsp_due_q[$];
    int          n_queued   = 0;
    int          n_accepted = 0;
    int          err_count  = 0;
    bit          idle_on    = 1'b1;
    int          hold_asked = 0;
    logic [31:0] clock_ms   = '0;

    // predicted block state
    ieqar_pkg::t_cfg cfg_now = '{delay_ms:  ieqar_pkg::DELAY_RST,
                                 period_ms: ieqar_pkg::PERIOD_RST,
                                 key_type:  ieqar_pkg::KEY_RST};
    ieqar_pkg::t_slot ring_img [RING_N];
    logic [7:0]  rd_ptr     = '0;
    logic [8:0]  fill_cnt   = '0;
    logic        key_held   = 1'b0;
    logic [15:0] key_code   = '0;
    logic [31:0] repeat_due = '0;
    logic [31:0] push_cnt   = '0;
    logic [31:0] drop_cnt   = '0;
    logic [31:0] pop_cnt    = '0;

    // store one event, or count it as dropped when the ring is full
    function automatic logic [1:0] ring_store(input ieqar_pkg::t_slot s);
        int idx;
        if (fill_cnt >= RING_N) begin
            drop_cnt++;
            return ieqar_pkg::ST_DROP;
        end
        idx = (int'(rd_ptr) + int'(fill_cnt)) % RING_N;
        ring_img[idx] = s;
        fill_cnt++;
        push_cnt++;
        return ieqar_pkg::ST_OK;
    endfunction

    // expected result of one accepted request
    function automatic ieqar_pkg::t_rsp event_queue_step(input ieqar_pkg::t_req r);
        ieqar_pkg::t_rsp  rsp;
        ieqar_pkg::t_slot s;
        rsp = '0;
        rsp.status = ieqar_pkg::ST_NONE;
        case (r.action)
            ieqar_pkg::ACT_PUSH: begin
                s.time_ms  = r.now_ms;
                s.ev_type  = r.in_type;
                s.ev_code  = r.in_code;
                s.ev_value = r.in_value;
                rsp.status = ring_store(s);
                // only an accepted key event touches the repeater
                if (rsp.status == ieqar_pkg::ST_OK && r.in_type == cfg_now.key_type) begin
                    if (r.in_value == ieqar_pkg::KEY_PRESS) begin
                        key_held   = 1'b1;
                        key_code   = r.in_code;
                        repeat_due = r.now_ms + 32'(cfg_now.delay_ms);
                    end else if (r.in_value == ieqar_pkg::KEY_RELEASE && key_held
                                 && key_code == r.in_code) begin
                        key_held = 1'b0;
                    end
                end
            end
            ieqar_pkg::ACT_TICK: begin
                if (key_held && r.now_ms >= repeat_due) begin
                    repeat_due = repeat_due + 32'(cfg_now.period_ms);
                    s.time_ms  = r.now_ms;
                    s.ev_type  = cfg_now.key_type;
                    s.ev_code  = key_code;
                    s.ev_value = ieqar_pkg::KEY_REPEAT;
                    rsp.status = ring_store(s);
                end
            end
            ieqar_pkg::ACT_POP: begin
                if (fill_cnt != 0) begin
                    s = ring_img[rd_ptr];
                    rsp.out_time_ms = s.time_ms;
                    rsp.out_type    = s.ev_type;
                    rsp.out_code    = s.ev_code;
                    rsp.out_value   = s.ev_value;
                    rd_ptr   = 8'((int'(rd_ptr) + 1) % RING_N);
                    fill_cnt--;
                    pop_cnt++;
                    rsp.status = ieqar_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        rsp.pending_count = fill_cnt;
        rsp.pushed_total  = push_cnt;
        rsp.dropped_total = drop_cnt;
        rsp.read_total    = pop_cnt;
        return rsp;
    endfunction

    // idle length: mostly short, a few long, none when idling is off
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 87)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // mismatch report
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 100)
            $display("tb: mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_rsp(input ieqar_pkg::t_rsp got, input ieqar_pkg::t_rsp want);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.out_time_ms !== want.out_time_ms)
            report_mismatch("out_time_ms", got.out_time_ms, want.out_time_ms);
        if (got.out_type !== want.out_type)
            report_mismatch("out_type", 32'(got.out_type), 32'(want.out_type));
        if (got.out_code !== want.out_code)
            report_mismatch("out_code", 32'(got.out_code), 32'(want.out_code));
        if (got.out_value !== want.out_value)
            report_mismatch("out_value", got.out_value, want.out_value);
        if (got.pending_count !== want.pending_count)
            report_mismatch("pending_count", 32'(got.pending_count), 32'(want.pending_count));
        if (got.pushed_total !== want.pushed_total)
            report_mismatch("pushed_total", got.pushed_total, want.pushed_total);
        if (got.dropped_total !== want.dropped_total)
            report_mismatch("dropped_total", got.dropped_total, want.dropped_total);
        if (got.read_total !== want.read_total)
            report_mismatch("read_total", got.read_total, want.read_total);
    endtask

    // request driver
    int gap_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                rsp_due_q.push_back(event_queue_step(in_req));
                n_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (req_todo_q.size() > 0) begin
                    in_req   <= req_todo_q.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall, with a long hold-off on request
    int stall_left  = 0;
    int hold_served = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            stall_left  <= LONG_HOLD;
            out_stall   <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else begin
            int g;
            g = pick_gap();
            out_stall <= (g > 0);
            if (g > 0)
                stall_left <= g - 1;
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (rsp_due_q.size() == 0)
                report_mismatch("result with none expected", '0, '0);
            else
                check_rsp(out_rsp, rsp_due_q.pop_front());
        end
    end

    // stimulus helpers
    task automatic queue_req(input logic [1:0] act, input logic [31:0] now,
                             input logic [15:0] typ, input logic [15:0] code,
                             input logic signed [31:0] value);
        ieqar_pkg::t_req r;
        r.action   = act;
        r.now_ms   = now;
        r.in_type  = typ;
        r.in_code  = code;
        r.in_value = value;
        req_todo_q.push_back(r);
        n_queued++;
    endtask

    // random request with the given mix; the rest of the mix is the unused action
    task automatic queue_random(input int push_w, input int tick_w, input int pop_w,
                                input int step_max);
        ieqar_pkg::t_req r;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < push_w)
            r.action = ieqar_pkg::ACT_PUSH;
        else if (pick < push_w + tick_w)
            r.action = ieqar_pkg::ACT_TICK;
        else if (pick < push_w + tick_w + pop_w)
            r.action = ieqar_pkg::ACT_POP;
        else
            r.action = ACT_NONE;
        if ($urandom_range(0, 99) < 2)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + 32'($urandom_range(0, step_max));
        r.now_ms  = clock_ms;
        r.in_type = ($urandom_range(0, 99) < 65) ? cfg_now.key_type : 16'($urandom());
        r.in_code = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 3))
                                                 : 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.in_value = ieqar_pkg::KEY_PRESS;
        else if (pick < 75)
            r.in_value = ieqar_pkg::KEY_RELEASE;
        else if (pick < 82)
            r.in_value = ieqar_pkg::KEY_REPEAT;
        else
            r.in_value = $urandom();
        req_todo_q.push_back(r);
        n_queued++;
    endtask

    // wait until every request is in and every result is out
    task automatic wait_idle();
        while (n_accepted != n_queued || rsp_due_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ieqar_pkg::REG_DELAY:  cfg_now.delay_ms  = value;
            ieqar_pkg::REG_PERIOD: cfg_now.period_ms = value;
            ieqar_pkg::REG_KEY:    cfg_now.key_type  = value;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] delay, input logic [15:0] period,
                             input logic [15:0] key);
        reg_write(ieqar_pkg::REG_DELAY, delay);
        reg_write(ieqar_pkg::REG_PERIOD, period);
        reg_write(ieqar_pkg::REG_KEY, key);
    endtask

    // main sequence
    initial begin
        int          n_fill;
        int          step_max;
        logic [15:0] other;
        logic [15:0] dly;
        logic [15:0] per;
        logic [15:0] key;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests with reset register values
        queue_req(ieqar_pkg::ACT_POP,  32'h0, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'shFFFF_FFFF);
        queue_req(ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'shFFFF_FFFF);
        queue_req(ieqar_pkg::ACT_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'sh8000_0000);
        queue_req(ieqar_pkg::ACT_PUSH, 32'h0, 16'h0, 16'h0, 32'sh7FFF_FFFF);
        // press value on a non-key type
        queue_req(ieqar_pkg::ACT_PUSH, 32'd10, 16'h0, 16'd5, ieqar_pkg::KEY_PRESS);
        queue_req(ieqar_pkg::ACT_PUSH, 32'd1000, ieqar_pkg::KEY_RST, 16'd5,
                  ieqar_pkg::KEY_PRESS);
        // first repeat just at the deadline, then one period later
        queue_req(ieqar_pkg::ACT_TICK, 32'd1499, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_TICK, 32'd1500, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_TICK, 32'd1532, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_TICK, 32'd1533, 16'h0, 16'h0, 32'sh0);
        // repeat value and other key values leave the repeater alone
        queue_req(ieqar_pkg::ACT_PUSH, 32'd1540, ieqar_pkg::KEY_RST, 16'd5,
                  ieqar_pkg::KEY_REPEAT);
        queue_req(ieqar_pkg::ACT_PUSH, 32'd1550, ieqar_pkg::KEY_RST, 16'd5, -32'sd1);
        // release of another code does not disarm
        queue_req(ieqar_pkg::ACT_PUSH, 32'd1600, ieqar_pkg::KEY_RST, 16'd6,
                  ieqar_pkg::KEY_RELEASE);
        queue_req(ieqar_pkg::ACT_TICK, 32'd2000, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_PUSH, 32'd2100, ieqar_pkg::KEY_RST, 16'd5,
                  ieqar_pkg::KEY_RELEASE);
        queue_req(ieqar_pkg::ACT_TICK, 32'd3000, 16'h0, 16'h0, 32'sh0);
        // deadline wraps past 2^32
        queue_req(ieqar_pkg::ACT_PUSH, 32'hFFFF_FF00, ieqar_pkg::KEY_RST, 16'hFFFF,
                  ieqar_pkg::KEY_PRESS);
        queue_req(ieqar_pkg::ACT_TICK, 32'hFFFF_FF10, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_PUSH, 32'hFFFF_FF20, ieqar_pkg::KEY_RST, 16'hFFFF,
                  ieqar_pkg::KEY_RELEASE);
        repeat (5) queue_req(ieqar_pkg::ACT_POP, 32'h0, 16'h0, 16'h0, 32'sh0);
        wait_idle();

        // zero delay and zero period: every tick at or after the press time fires
        write_all(16'd0, 16'd0, 16'hFFFF);
        queue_req(ieqar_pkg::ACT_PUSH, 32'd50, 16'hFFFF, 16'd1, ieqar_pkg::KEY_PRESS);
        queue_req(ieqar_pkg::ACT_TICK, 32'd49, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_TICK, 32'd50, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_TICK, 32'd50, 16'h0, 16'h0, 32'sh0);
        repeat (4) queue_req(ieqar_pkg::ACT_POP, 32'h0, 16'h0, 16'h0, 32'sh0);
        wait_idle();

        // fill the ring, drop pushes and repeats, then drain it
        write_all(ieqar_pkg::DELAY_RST, ieqar_pkg::PERIOD_RST, ieqar_pkg::KEY_RST);
        other  = ieqar_pkg::KEY_RST + 16'd1;
        queue_req(ieqar_pkg::ACT_PUSH, 32'd5000, ieqar_pkg::KEY_RST, 16'd9,
                  ieqar_pkg::KEY_PRESS);
        n_fill = RING_N - int'(fill_cnt) - 1;
        for (int i = 0; i < n_fill; i++)
            queue_req(ieqar_pkg::ACT_PUSH, 32'd5000 + 32'(i), other, 16'($urandom()),
                      $urandom());
        queue_req(ieqar_pkg::ACT_PUSH, 32'd5400, other, 16'd1, 32'sd7);
        // dropped press must not re-arm with code 3
        queue_req(ieqar_pkg::ACT_PUSH, 32'd5410, ieqar_pkg::KEY_RST, 16'd3,
                  ieqar_pkg::KEY_PRESS);
        queue_req(ieqar_pkg::ACT_TICK, 32'd5600, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_TICK, 32'd5600, 16'h0, 16'h0, 32'sh0);
        repeat (2) queue_req(ieqar_pkg::ACT_POP, 32'h0, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_TICK, 32'd5600, 16'h0, 16'h0, 32'sh0);
        queue_req(ieqar_pkg::ACT_PUSH, 32'd5700, ieqar_pkg::KEY_RST, 16'd9,
                  ieqar_pkg::KEY_RELEASE);
        queue_req(ieqar_pkg::ACT_TICK, 32'd9000, 16'h0, 16'h0, 32'sh0);
        repeat (RING_N + 3) queue_req(ieqar_pkg::ACT_POP, 32'h0, 16'h0, 16'h0, 32'sh0);
        wait_idle();

        // random phases, each with its own register setting and mix
        clock_ms = 32'd6000;
        for (int p = 0; p < 9; p++) begin
            case (p % 4)
                0: begin
                    dly = (p == 0) ? 16'hFFFF : 16'($urandom());
                    per = (p == 0) ? 16'hFFFF : 16'($urandom());
                    key = (p == 0) ? 16'h0 : 16'($urandom());
                end
                1: begin
                    dly = 16'($urandom_range(0, 300));
                    per = 16'd1;
                    key = ieqar_pkg::KEY_RST;
                end
                2: begin
                    dly = 16'($urandom_range(0, 600));
                    per = 16'($urandom_range(1, 80));
                    key = 16'hFFFF;
                end
                default: begin
                    dly = 16'($urandom_range(0, 600));
                    per = 16'($urandom_range(0, 80));
                    key = 16'($urandom());
                end
            endcase
            write_all(dly, per, key);
            step_max = int'(cfg_now.delay_ms) / 8 + int'(cfg_now.period_ms) + 4;
            idle_on  = !(p == 2 || p == 6);
            for (int i = 0; i < 40; i++) begin
                case (p % 3)
                    0:       queue_random(45, 25, 28, step_max);
                    1:       queue_random(75, 15, 8, step_max);
                    default: queue_random(15, 15, 68, step_max);
                endcase
                // sender pause until all results are back
                if (p == 5 && i == 19)
                    wait_idle();
            end
            // receiver holds off while requests keep coming
            if (p == 3 || p == 7)
                hold_asked++;
            wait_idle();
        end

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial begin
        #4ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ieqar_pkg.sv
rtl/core/ieqar_ram.sv
rtl/core/ieqar_ctrl.sv
rtl/core/ieqar_dp.sv
rtl/core/input_event_queue_with_autorepeat.sv
dv/testbench.sv
